@@ hw/rtl/hrfp_pkg.sv @@
package hrfp_pkg;

    // NAL length field width
    localparam int LEN_W = 24;
    // payload limit register width
    localparam int MAXP_W = 11;
    localparam int SEQ_W = 16;
    localparam int TS_W = 32;
    localparam int CFG_DATA_W = 32;

    localparam logic [MAXP_W-1:0] MAXP_RESET = MAXP_W'(1200);

    // start code holding buffer
    localparam int HELD_N = 4;
    localparam int HELD_AW = 2;

    // command queue between front and back
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW = 2;
    localparam int CMDQ_CW = 3;

    localparam logic [4:0] FU_A_TYPE = 5'd28;

    typedef enum logic [1:0] {
        CFG_PAYLOAD_TYPE = 2'd0,
        CFG_SSRC         = 2'd1,
        CFG_MAX_PAYLOAD  = 2'd2,
        CFG_INIT_SEQ     = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        PH_CHECK,
        PH_NONE,
        PH_CODE3,
        PH_CODE4
    } phase_t;

    typedef enum logic [1:0] {
        DEC_WAIT,
        DEC_NONE,
        DEC_3,
        DEC_4
    } dec_t;

    typedef enum logic [1:0] {
        SUB_IND,
        SUB_HDR,
        SUB_DATA
    } sub_t;

    typedef struct packed {
        logic [7:0]       nal_byte;
        logic [LEN_W-1:0] nal_length;
        logic [TS_W-1:0]  frame_timestamp;
    } nal_t;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             packet_start;
        logic             packet_end;
        logic             marker_bit;
        logic [SEQ_W-1:0] sequence_number;
        logic [TS_W-1:0]  packet_timestamp;
        logic             run_last;
    } pkt_t;

    // one NAL data byte as handed from front to back
    typedef struct packed {
        logic [7:0]      data;
        logic            first;     // NAL header byte
        logic            last;      // last byte of the NAL
        logic            ebit;      // remaining bytes fit in one chunk
        logic            frag;      // NAL goes out as FU-A
        logic            step_end;  // last command of its input beat
        logic [TS_W-1:0] ts;
    } cmd_t;

    typedef struct packed {
        logic             load;
        logic [SEQ_W-1:0] value;
    } seq_ld_t;

    function automatic logic [MAXP_W-1:0] chunk_limit(input logic [MAXP_W-1:0] maxp);
        logic [MAXP_W-1:0] r;
        r = (maxp >= MAXP_W'(3)) ? (maxp - MAXP_W'(2)) : MAXP_W'(1);
        return r;
    endfunction

    // true when the bytes from pos to the end of the NAL fit in one chunk
    function automatic logic ends_chunk(input logic [LEN_W-1:0]  len,
                                        input logic [LEN_W-1:0]  pos,
                                        input logic [MAXP_W-1:0] lim);
        logic r;
        r = (len <= pos) || ((len - pos) <= {{(LEN_W-MAXP_W){1'b0}}, lim});
        return r;
    endfunction

endpackage

@@ hw/rtl/hrfp_cmd_fifo.sv @@
module hrfp_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  hrfp_pkg::cmd_t wdata,
    output logic          full,
    input  logic          pop,
    output hrfp_pkg::cmd_t rdata,
    output logic          valid
);
    import hrfp_pkg::*;

    cmd_t               mem [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] wr_ptr_reg;
    logic [CMDQ_AW-1:0] rd_ptr_reg;
    logic [CMDQ_CW-1:0] count_reg;
    logic               do_push;
    logic               do_pop;

    assign full    = (count_reg == CMDQ_CW'(CMDQ_DEPTH));
    assign valid   = (count_reg != '0);
    assign do_push = push && !full;
    assign do_pop  = pop && valid;
    assign rdata   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + CMDQ_AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + CMDQ_AW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CMDQ_CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CMDQ_CW'(1);
            end
        end
    end

    // front must honor full
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("cmd fifo pushed while full");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CMDQ_CW'(CMDQ_DEPTH))
        else $error("cmd fifo count overflow");

endmodule

@@ hw/rtl/hrfp_front.sv @@
module hrfp_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  hrfp_pkg::nal_t             nal,
    input  logic [hrfp_pkg::MAXP_W-1:0] pay_max,
    input  logic [hrfp_pkg::MAXP_W-1:0] lim,
    input  logic                       q_full,
    output logic                       cmd_push,
    output hrfp_pkg::cmd_t             cmd
);
    import hrfp_pkg::*;

    phase_t             phase_reg, phase_next;
    logic [2:0]         held_count_reg, held_count_next;
    logic [LEN_W-1:0]   bytes_seen_reg, bytes_seen_next;
    logic               frag_reg, frag_next;
    logic [TS_W-1:0]    ts_reg, ts_next;
    logic [7:0]         held_reg [HELD_N];

    // release of held bytes when no start code matched
    logic               rel_active_reg, rel_active_next;
    logic [HELD_AW-1:0] rel_idx_reg, rel_idx_next;
    logic [HELD_AW-1:0] rel_end_reg, rel_end_next;
    logic [LEN_W-1:0]   rel_len_reg, rel_len_next;
    logic               rel_last_reg, rel_last_next;
    logic               rel_frag_reg, rel_frag_next;

    logic               accept;
    logic [LEN_W-1:0]   len_eff;
    logic               last;
    logic [2:0]         k;
    dec_t               dec;
    logic [2:0]         dec_len;
    logic [LEN_W-1:0]   size;
    logic               frag_dec;
    logic [TS_W-1:0]    ts_now;
    logic [2:0]         cl;

    assign full     = rel_active_reg || q_full;
    assign accept   = push && !full;
    assign len_eff  = (nal.nal_length == '0) ? LEN_W'(1) : nal.nal_length;
    assign last     = ({1'b0, bytes_seen_reg} + (LEN_W+1)'(1)) >= {1'b0, len_eff};
    assign k        = held_count_reg + 3'd1;
    assign ts_now   = (bytes_seen_reg == '0) ? nal.frame_timestamp : ts_reg;
    assign size     = (len_eff > LEN_W'(dec_len)) ? (len_eff - LEN_W'(dec_len)) : '0;
    assign frag_dec = size > {{(LEN_W-MAXP_W){1'b0}}, pay_max};

    // start code decision for the current byte
    always_comb
    begin
        dec = DEC_NONE;
        case (k) inside
            3'd1, 3'd2:
            begin
                dec = (nal.nal_byte != 8'd0 || last) ? DEC_NONE : DEC_WAIT;
            end
            3'd3:
            begin
                if (nal.nal_byte == 8'd1)
                    dec = DEC_3;
                else if (nal.nal_byte == 8'd0 && !last)
                    dec = DEC_WAIT;
                else
                    dec = DEC_NONE;
            end
            default:
            begin
                dec = (nal.nal_byte == 8'd1) ? DEC_4 : DEC_NONE;
            end
        endcase
    end

    always_comb
    begin
        unique case (dec)
            DEC_3:   dec_len = 3'd3;
            DEC_4:   dec_len = 3'd4;
            default: dec_len = 3'd0;
        endcase
    end

    always_comb
    begin
        unique case (phase_reg)
            PH_CODE3: cl = 3'd3;
            PH_CODE4: cl = 3'd4;
            default:  cl = 3'd0;
        endcase
    end

    // next state
    always_comb
    begin
        phase_next      = phase_reg;
        held_count_next = held_count_reg;
        bytes_seen_next = bytes_seen_reg;
        frag_next       = frag_reg;
        ts_next         = ts_reg;
        rel_active_next = rel_active_reg;
        rel_idx_next    = rel_idx_reg;
        rel_end_next    = rel_end_reg;
        rel_len_next    = rel_len_reg;
        rel_last_next   = rel_last_reg;
        rel_frag_next   = rel_frag_reg;

        if (rel_active_reg && !q_full)
        begin
            if (rel_idx_reg == rel_end_reg)
                rel_active_next = 1'b0;
            else
                rel_idx_next = rel_idx_reg + HELD_AW'(1);
        end

        if (accept)
        begin
            ts_next = ts_now;
            if (phase_reg == PH_CHECK)
            begin
                held_count_next = k;
                if (dec != DEC_WAIT)
                begin
                    frag_next = frag_dec;
                    unique case (dec)
                        DEC_3:   phase_next = PH_CODE3;
                        DEC_4:   phase_next = PH_CODE4;
                        default: phase_next = PH_NONE;
                    endcase
                end
                if (dec == DEC_NONE)
                begin
                    rel_active_next = 1'b1;
                    rel_idx_next    = '0;
                    rel_end_next    = held_count_reg[HELD_AW-1:0];
                    rel_len_next    = len_eff;
                    rel_last_next   = last;
                    rel_frag_next   = frag_dec;
                end
            end
            if (last)
            begin
                held_count_next = '0;
                bytes_seen_next = '0;
                phase_next      = PH_CHECK;
                frag_next       = 1'b0;
            end
            else
            begin
                bytes_seen_next = bytes_seen_reg + LEN_W'(1);
            end
        end
    end

    // outputs
    always_comb
    begin
        if (rel_active_reg)
        begin
            cmd_push      = !q_full;
            cmd.data      = held_reg[rel_idx_reg];
            cmd.first     = (rel_idx_reg == '0);
            cmd.last      = rel_last_reg && (rel_idx_reg == rel_end_reg);
            cmd.ebit      = ends_chunk(rel_len_reg, LEN_W'(rel_idx_reg), lim);
            cmd.frag      = rel_frag_reg;
            cmd.step_end  = (rel_idx_reg == rel_end_reg);
            cmd.ts        = ts_reg;
        end
        else
        begin
            cmd_push      = accept && (phase_reg != PH_CHECK);
            cmd.data      = nal.nal_byte;
            cmd.first     = (bytes_seen_reg == LEN_W'(cl));
            cmd.last      = last;
            cmd.ebit      = ends_chunk(len_eff, bytes_seen_reg, lim);
            cmd.frag      = frag_reg;
            cmd.step_end  = 1'b1;
            cmd.ts        = ts_now;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && phase_reg == PH_CHECK)
        begin
            held_reg[held_count_reg[HELD_AW-1:0]] <= nal.nal_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_CHECK;
            held_count_reg <= '0;
            bytes_seen_reg <= '0;
            frag_reg       <= 1'b0;
            ts_reg         <= '0;
            rel_active_reg <= 1'b0;
            rel_idx_reg    <= '0;
            rel_end_reg    <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            held_count_reg <= held_count_next;
            bytes_seen_reg <= bytes_seen_next;
            frag_reg       <= frag_next;
            ts_reg         <= ts_next;
            rel_active_reg <= rel_active_next;
            rel_idx_reg    <= rel_idx_next;
            rel_end_reg    <= rel_end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rel_len_reg  <= rel_len_next;
        rel_last_reg <= rel_last_next;
        rel_frag_reg <= rel_frag_next;
    end

    a_rel_done: assert property (@(posedge clk) disable iff (!rst_n)
        rel_active_reg && !q_full && rel_idx_reg == rel_end_reg |=> !rel_active_reg)
        else $error("held byte release overran");

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_CHECK |-> held_count_reg < 3'(HELD_N))
        else $error("start code check held too many bytes");

endmodule

@@ hw/rtl/hrfp_back.sv @@
module hrfp_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    input  hrfp_pkg::cmd_t              cmd,
    output logic                        cmd_pop,
    input  logic [hrfp_pkg::MAXP_W-1:0] lim,
    input  hrfp_pkg::seq_ld_t           seq_ld,
    output logic                        empty,
    input  logic                        pop,
    output hrfp_pkg::pkt_t              pkt
);
    import hrfp_pkg::*;

    sub_t              sub_reg, sub_next;
    logic [SEQ_W-1:0]  seq_reg, seq_next;
    logic [MAXP_W-1:0] fill_reg, fill_next;
    logic              first_chunk_reg, first_chunk_next;
    logic [7:0]        fu_ind_reg, fu_ind_next;
    logic [4:0]        fu_type_reg, fu_type_next;
    logic              out_valid_reg;
    pkt_t              pkt_reg;

    logic              can_emit;
    logic              step;
    logic              emit;
    logic              data_sel;
    pkt_t              beat;
    logic [MAXP_W-1:0] fill_inc;
    logic              chunk_end;

    assign empty     = !out_valid_reg;
    assign pkt       = pkt_reg;
    assign can_emit  = !out_valid_reg || pop;
    assign step      = cmd_valid && can_emit;
    assign fill_inc  = fill_reg + MAXP_W'(1);
    assign chunk_end = cmd.last || (fill_inc >= lim);

    // next sub-step within a fragmented data byte
    always_comb
    begin
        sub_next = sub_reg;
        if (step && cmd.frag && !cmd.first)
        begin
            unique case (sub_reg)
                SUB_IND:  sub_next = (fill_reg == '0) ? SUB_HDR : SUB_IND;
                SUB_HDR:  sub_next = SUB_DATA;
                SUB_DATA: sub_next = SUB_IND;
                default:  sub_next = SUB_IND;
            endcase
        end
    end

    // beats and datapath updates
    always_comb
    begin
        emit             = 1'b0;
        cmd_pop          = 1'b0;
        data_sel         = 1'b0;
        beat             = '0;
        seq_next         = seq_reg;
        fill_next        = fill_reg;
        first_chunk_next = first_chunk_reg;
        fu_ind_next      = fu_ind_reg;
        fu_type_next     = fu_type_reg;

        beat.sequence_number  = seq_reg;
        beat.packet_timestamp = cmd.ts;

        if (step)
        begin
            if (!cmd.frag)
            begin
                emit              = 1'b1;
                cmd_pop           = 1'b1;
                beat.out_byte     = cmd.data;
                beat.packet_start = cmd.first;
                beat.packet_end   = cmd.last;
                beat.marker_bit   = cmd.last;
                beat.run_last     = cmd.step_end;
                if (cmd.last)
                    seq_next = seq_reg + SEQ_W'(1);
            end
            else if (cmd.first)
            begin
                // NAL header: keep NRI/F for the indicator, type for the FU header
                cmd_pop      = 1'b1;
                fu_ind_next  = {cmd.data[7:5], FU_A_TYPE};
                fu_type_next = cmd.data[4:0];
            end
            else
            begin
                unique case (sub_reg)
                    SUB_IND:
                    begin
                        if (fill_reg == '0)
                        begin
                            emit              = 1'b1;
                            beat.out_byte     = fu_ind_reg;
                            beat.packet_start = 1'b1;
                        end
                        else
                        begin
                            data_sel = 1'b1;
                        end
                    end
                    SUB_HDR:
                    begin
                        emit          = 1'b1;
                        beat.out_byte = {first_chunk_reg, cmd.ebit, 1'b0, fu_type_reg};
                    end
                    default:
                    begin
                        data_sel = 1'b1;
                    end
                endcase
            end

            if (data_sel)
            begin
                emit            = 1'b1;
                cmd_pop         = 1'b1;
                beat.out_byte   = cmd.data;
                beat.packet_end = chunk_end;
                beat.marker_bit = chunk_end && cmd.last;
                beat.run_last   = cmd.step_end;
                if (chunk_end)
                begin
                    seq_next         = seq_reg + SEQ_W'(1);
                    fill_next        = '0;
                    first_chunk_next = 1'b0;
                end
                else
                begin
                    fill_next = fill_inc;
                end
            end

            if (cmd_pop && cmd.last)
            begin
                fill_next        = '0;
                first_chunk_next = 1'b1;
            end
        end

        if (seq_ld.load)
            seq_next = seq_ld.value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg         <= SUB_IND;
            seq_reg         <= '0;
            fill_reg        <= '0;
            first_chunk_reg <= 1'b1;
            fu_ind_reg      <= '0;
            fu_type_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            sub_reg         <= sub_next;
            seq_reg         <= seq_next;
            fill_reg        <= fill_next;
            first_chunk_reg <= first_chunk_next;
            fu_ind_reg      <= fu_ind_next;
            fu_type_reg     <= fu_type_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            pkt_reg <= beat;
    end

    a_sub_holds_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        sub_reg != SUB_IND |-> cmd_valid && cmd.frag)
        else $error("fragment expansion lost its command");

    a_hdr_at_chunk_start: assert property (@(posedge clk) disable iff (!rst_n)
        sub_reg == SUB_HDR |-> fill_reg == '0)
        else $error("FU header outside chunk start");

endmodule

@@ hw/rtl/h264_rtp_fua_packetizer.sv @@
// Path: an input byte is written to the command queue at the accepting edge; its first
//   payload beat then moves into the output register; held bytes of a NAL with no start
//   code come after. Throughput: one input byte per cycle while full is low, one output
//   beat per cycle while pop keeps up; each FU-A fragment adds two header beats,
//   absorbed by a 4-entry command queue. No start code: input stalls during release.
// Reset: rst_n is asynchronous, active low; all control state clears at once, no sweep.
module h264_rtp_fua_packetizer (
    input  logic                            clk,
    input  logic                            rst_n,
    // NAL byte input, queue style
    input  logic                            push,
    output logic                            full,
    input  hrfp_pkg::nal_t                  nal,
    // packet byte output, queue style
    output logic                            empty,
    input  logic                            pop,
    output hrfp_pkg::pkt_t                  pkt,
    // register writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  hrfp_pkg::cfg_idx_t              cfg_index,
    input  logic [hrfp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import hrfp_pkg::*;

    // Only the payload limit and the sequence seed affect the byte stream. Payload
    // type and SSRC belong to the RTP header, which is built downstream, so those
    // writes are taken and dropped here.
    logic [MAXP_W-1:0] pay_max_reg;
    logic [MAXP_W-1:0] lim;
    logic              cfg_wr;
    seq_ld_t           seq_ld;

    logic              q_full;
    logic              q_push;
    cmd_t              q_wdata;
    logic              q_valid;
    logic              q_pop;
    cmd_t              q_rdata;

    assign cfg_ready    = 1'b1;
    assign cfg_wr       = cfg_valid && cfg_ready;
    assign seq_ld.load  = cfg_wr && (cfg_index == CFG_INIT_SEQ);
    assign seq_ld.value = cfg_data[SEQ_W-1:0];

    // FU-A chunk payload is the packet limit minus indicator and header, at least one byte
    assign lim = chunk_limit(pay_max_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pay_max_reg <= MAXP_RESET;
        end
        else if (cfg_wr && cfg_index == CFG_MAX_PAYLOAD)
        begin
            pay_max_reg <= cfg_data[MAXP_W-1:0];
        end
    end

    // Front: start code stripping, single/FU-A choice, per-byte classification.
    // Each surviving NAL byte becomes one command beat.
    hrfp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .nal         (nal),
        .pay_max     (pay_max_reg),
        .lim         (lim),
        .q_full      (q_full),
        .cmd_push    (q_push),
        .cmd         (q_wdata)
    );

    // Decouples byte intake from header insertion on the output side.
    hrfp_cmd_fifo u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .valid (q_valid)
    );

    // Back: expands commands into payload beats (FU indicator, FU header, data),
    // tracks chunk fill and the sequence counter, owns the output register.
    hrfp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd       (q_rdata),
        .cmd_pop   (q_pop),
        .lim       (lim),
        .seq_ld    (seq_ld),
        .empty     (empty),
        .pop       (pop),
        .pkt       (pkt)
    );

endmodule

@@ dv/fua_packet_checker.sv @@
`timescale 1ns / 100ps

module fua_packet_checker
    import hrfp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic                  full,
    input  nal_t                  nal,
    input  logic                  empty,
    input  logic                  pop,
    input  pkt_t                  pkt,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  cfg_idx_t              cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    errors,
    output int                    pending
);

    localparam int REPORT_MAX = 10;
    localparam logic [7:0] S_BIT = 8'h80;
    localparam logic [7:0] E_BIT = 8'h40;

    // register copies
    logic [6:0]        pt_reg;
    logic [31:0]       ssrc_reg;
    logic [MAXP_W-1:0] maxp_reg;
    logic [SEQ_W-1:0]  init_seq_reg;

    // packetizer state
    logic [7:0]        held [HELD_N];
    logic [2:0]        held_cnt;
    logic [LEN_W-1:0]  seen;
    phase_t            phase;
    logic              frag;
    logic [7:0]        fu_ind;
    logic [4:0]        fu_type;
    logic [MAXP_W-1:0] fill;
    logic              first_chunk;
    logic [SEQ_W-1:0]  seq;
    logic [TS_W-1:0]   ts_latch;

    pkt_t expected_beats [$];
    pkt_t step_beats [$];

    function automatic string beat_str(input pkt_t p);
        return $sformatf("byte %h start %b end %b mark %b seq %h ts %h last %b",
                         p.out_byte, p.packet_start, p.packet_end, p.marker_bit,
                         p.sequence_number, p.packet_timestamp, p.run_last);
    endfunction

    function automatic int code_len(input phase_t ph);
        return (ph == PH_CODE4) ? 4 : ((ph == PH_CODE3) ? 3 : 0);
    endfunction

    function automatic void restart_nal();
        held_cnt    = '0;
        seen        = '0;
        phase       = PH_CHECK;
        frag        = 1'b0;
        fill        = '0;
        first_chunk = 1'b1;
    endfunction

    function automatic void reset_model();
        pt_reg       = 7'd96;
        ssrc_reg     = '0;
        maxp_reg     = MAXP_RESET;
        init_seq_reg = '0;
        foreach (held[i])
            held[i] = '0;
        restart_nal();
        fu_ind   = '0;
        fu_type  = '0;
        seq      = '0;
        ts_latch = '0;
    endfunction

    function automatic void queue_beat(input logic [7:0] b, input logic st,
                                       input logic en, input logic mk);
        pkt_t p;
        p.out_byte         = b;
        p.packet_start     = st;
        p.packet_end       = en;
        p.marker_bit       = mk;
        p.sequence_number  = seq;
        p.packet_timestamp = ts_latch;
        p.run_last         = 1'b0;
        step_beats.insert(step_beats.size(), p);
    endfunction

    // d: offset of the byte after the start code, size: NAL bytes after the start code
    function automatic void route_data_byte(input logic [7:0] b, input longint d,
                                            input longint size, input bit last);
        longint     lim;
        longint     rem;
        logic [7:0] hdr;
        bit         ends;
        if (!frag)
        begin
            queue_beat(b, d == 0, last, last);
            if (last)
                seq = seq + 1'b1;
        end
        else if (d == 0)
        begin
            // NAL header byte: kept for the FU indicator and header, never sent
            fu_ind  = {b[7:5], FU_A_TYPE};
            fu_type = b[4:0];
        end
        else
        begin
            lim = (maxp_reg >= 3) ? longint'(maxp_reg) - 2 : 1;
            if (fill == 0)
            begin
                rem = (d < size) ? size - d : 0;
                hdr = {3'b000, fu_type};
                if (first_chunk)
                    hdr = hdr | S_BIT;
                if (rem <= lim)
                    hdr = hdr | E_BIT;
                queue_beat(fu_ind, 1'b1, 1'b0, 1'b0);
                queue_beat(hdr, 1'b0, 1'b0, 1'b0);
            end
            fill = fill + 1'b1;
            ends = last || (longint'(fill) >= lim);
            queue_beat(b, 1'b0, ends, ends && last);
            if (ends)
            begin
                seq         = seq + 1'b1;
                fill        = '0;
                first_chunk = 1'b0;
            end
        end
    endfunction

    function automatic void packetize_byte(input nal_t in);
        longint len;
        longint size;
        longint d;
        longint cl;
        bit     last;
        dec_t   dec;
        int     k;
        int     i;
        len = longint'(in.nal_length);
        if (len == 0)
            len = 1;
        if (seen == 0)
            ts_latch = in.frame_timestamp;
        last = (longint'(seen) + 1 >= len);
        step_beats.delete();

        if (phase == PH_CHECK)
        begin
            held[held_cnt[HELD_AW-1:0]] = in.nal_byte;
            held_cnt = held_cnt + 1'b1;
            k = int'(held_cnt);
            if (k <= 2)
                dec = (in.nal_byte != 8'h00 || last) ? DEC_NONE : DEC_WAIT;
            else if (k == 3)
                dec = (in.nal_byte == 8'h01) ? DEC_3 :
                      ((in.nal_byte == 8'h00 && !last) ? DEC_WAIT : DEC_NONE);
            else
                dec = (in.nal_byte == 8'h01) ? DEC_4 : DEC_NONE;

            if (dec != DEC_WAIT)
            begin
                case (dec)
                    DEC_3:   phase = PH_CODE3;
                    DEC_4:   phase = PH_CODE4;
                    default: phase = PH_NONE;
                endcase
                cl          = code_len(phase);
                size        = (len > cl) ? len - cl : 0;
                frag        = (size > longint'(maxp_reg));
                fill        = '0;
                first_chunk = 1'b1;
                // no start code: held bytes go out as NAL data
                if (phase == PH_NONE)
                    for (i = 0; i < k && i < HELD_N; i++)
                        route_data_byte(held[i], i, size, last && (i + 1 == k));
            end
        end
        else
        begin
            cl   = code_len(phase);
            d    = (longint'(seen) >= cl) ? longint'(seen) - cl : 0;
            size = (len > cl) ? len - cl : 0;
            route_data_byte(in.nal_byte, d, size, last);
        end

        if (last)
            restart_nal();
        else
            seen = seen + 1'b1;

        if (step_beats.size() > 0)
            step_beats[step_beats.size() - 1].run_last = 1'b1;
        foreach (step_beats[j])
            expected_beats.insert(expected_beats.size(), step_beats[j]);
    endfunction

    function automatic void write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] v);
        case (idx)
            CFG_PAYLOAD_TYPE: pt_reg = v[6:0];
            CFG_SSRC:         ssrc_reg = v;
            CFG_MAX_PAYLOAD:  maxp_reg = v[MAXP_W-1:0];
            CFG_INIT_SEQ:
            begin
                init_seq_reg = v[SEQ_W-1:0];
                seq          = v[SEQ_W-1:0];
            end
            default: ;
        endcase
    endfunction

    function automatic void check_beat(input pkt_t got);
        pkt_t want;
        if (expected_beats.size() == 0)
        begin
            errors++;
            if (errors <= REPORT_MAX)
                $display("%0t: unexpected beat %s", $time, beat_str(got));
        end
        else
        begin
            want = expected_beats.pop_front();
            if (got.out_byte !== want.out_byte || got.packet_start !== want.packet_start ||
                got.packet_end !== want.packet_end || got.marker_bit !== want.marker_bit ||
                got.sequence_number !== want.sequence_number ||
                got.packet_timestamp !== want.packet_timestamp ||
                got.run_last !== want.run_last)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                begin
                    $display("%0t: beat mismatch", $time);
                    $display("    expected %s", beat_str(want));
                    $display("    actual   %s", beat_str(got));
                end
            end
        end
    endfunction

    // results are compared before the same edge's input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_model();
            expected_beats.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (pop && !empty)
                check_beat(pkt);
            if (cfg_valid && cfg_ready)
                write_reg(cfg_index, cfg_data);
            if (push && !full)
                packetize_byte(nal);
            pending = expected_beats.size();
        end
    end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import hrfp_pkg::*;

    localparam int  RANDOM_BYTES  = 170;    // rough size of the random part, in input beats
    localparam int  PHASE_BYTES   = 32;     // random beats per register setting
    localparam int  HOLD_CYCLES   = 120;    // long receiver hold-off
    localparam int  SETTLE_CYCLES = 12;     // well past the release and queue delays
    localparam int  DRAIN_LIMIT   = 20000;
    localparam time TIMEOUT       = 2ms;

    logic                  clk;
    logic                  rst_n;
    logic                  push;
    logic                  full;
    nal_t                  nal;
    logic                  empty;
    logic                  pop;
    pkt_t                  pkt;
    logic                  cfg_valid;
    logic                  cfg_ready;
    cfg_idx_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int errors;
    int pending;

    // sender side
    logic [7:0]        nal_bytes [$];   // NAL under construction, start code included
    int                burst_left;
    bit                gaps_on;
    logic [MAXP_W-1:0] maxp_now;        // payload limit last written, sizes random NALs

    // receiver side
    bit hold_req;
    int pop_odds [5] = '{100, 100, 85, 50, 15};

    h264_rtp_fua_packetizer i_dut (.*);

    fua_packet_checker i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: any hang (lost beat, stuck full) ends here.
    initial
    begin
        #(TIMEOUT);
        $display("end of test: mismatches");
        $finish;
    end

    // Receiver: pop pattern changes after each random span, from always-ready down to
    // mostly stalled. A hold request from the sender side forces a long stall, counted
    // here, so that the output queue and then the input side fill up.
    initial
    begin
        int odds;
        int span_left;
        int hold_left;
        pop       = 1'b0;
        odds      = 100;
        span_left = 0;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                pop <= 1'b0;
                hold_left--;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                pop <= 1'b0;
            end
            else
            begin
                if (span_left == 0)
                begin
                    odds      = pop_odds[$urandom_range(0, 4)];
                    span_left = $urandom_range(1, 40);
                end
                span_left--;
                pop <= ($urandom_range(0, 99) < odds);
            end
        end
    end

    // One input beat. Bursts of random length; between bursts an idle gap at random when gaps
    // are enabled, so idle cycles land at every point of a NAL.
    task automatic send_byte(input logic [7:0] b, input logic [LEN_W-1:0] len,
                             input logic [TS_W-1:0] ts);
        int   gap;
        nal_t beat;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (gaps_on && $urandom_range(0, 1)) ? $urandom_range(1, 12) : 0;
            if (gap > 0)
            begin
                @(negedge clk) push <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        beat.nal_byte        = b;
        beat.nal_length      = len;
        beat.frame_timestamp = ts;
        @(negedge clk);
        push <= 1'b1;
        nal  <= beat;
        @(posedge clk);
        while (full)
            @(posedge clk);
        burst_left--;
    endtask

    // Sends nal_bytes. With jitter the length on each beat but the last is a random
    // value large enough to keep the NAL open, and the last beat carries a length
    // that ends it (zero included): covers length changes and all length bits.
    task automatic send_nal(input bit jitter);
        int          n;
        int unsigned len;
        n = nal_bytes.size();
        for (int i = 0; i < n; i++)
        begin
            len = n;
            if (jitter)
                len = (i < n - 1) ? $urandom_range(i + 2, 24'hFF_FFFF) : $urandom_range(0, i + 1);
            // only the first beat's timestamp should be latched
            send_byte(nal_bytes[i], len[LEN_W-1:0], $urandom());
        end
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk) cfg_valid <= 1'b0;
        if (idx == CFG_MAX_PAYLOAD)
            maxp_now = value[MAXP_W-1:0];
    endtask

    // Stop sending, wait for every predicted beat, then let the block settle, since the
    // last NAL may end in beats that make no result (empty or header-only NAL).
    task automatic drain();
        int waited;
        @(negedge clk) push <= 1'b0;
        waited = 0;
        while (pending != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        burst_left = 0;
    endtask

    // Random NAL: mostly well-formed (four- or three-byte code, header, payload),
    // the rest empty NALs, NALs without a code and broken or overlong codes.
    // Payload sizes follow a payload limit below ten, so fragmentation is common.
    task automatic build_random_nal();
        int  pick;
        int  cap;
        int  body;
        bit  coded;
        pick  = $urandom_range(0, 99);
        coded = 1'b1;
        nal_bytes.delete();
        if (pick < 45)
            nal_bytes = '{8'h00, 8'h00, 8'h00, 8'h01};
        else if (pick < 75)
            nal_bytes = '{8'h00, 8'h00, 8'h01};
        else if (pick < 88)
            coded = 1'b0;
        else
        begin
            // 00, 00 00, ... up to five zeros, sometimes closed by a wrong byte
            coded = 1'b0;
            repeat ($urandom_range(1, 5)) nal_bytes.insert(nal_bytes.size(), 8'h00);
            if ($urandom_range(0, 1))
                nal_bytes.insert(nal_bytes.size(), 8'($urandom_range(2, 3)));
        end
        cap  = (maxp_now < 10) ? 3 * int'(maxp_now) + 4 : 24;
        body = (coded && $urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, cap);
        for (int i = 0; i < body; i++)
            nal_bytes.insert(nal_bytes.size(),
                             ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 1))
                                                         : 8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        int sent;
        int phase_sent;
        int step;
        rst_n      = 1'b0;
        push       = 1'b0;
        nal        = '0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_PAYLOAD_TYPE;
        cfg_data   = '0;
        hold_req   = 1'b0;
        burst_left = 0;
        gaps_on    = 1'b1;
        maxp_now   = MAXP_RESET;
        repeat (10) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // ---- directed ----
        // reset settings: four-byte code, whole NAL in one packet
        nal_bytes = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h65, 8'hAA};
        send_nal(1'b0);
        drain();
        write_reg(CFG_PAYLOAD_TYPE, 32'd127);
        write_reg(CFG_SSRC, 32'hFFFF_FFFF);
        write_reg(CFG_MAX_PAYLOAD, 32'd3);
        write_reg(CFG_INIT_SEQ, 32'h0000_FFFF);
        // three-byte code, one-byte FU-A chunks, sequence wraps past ffff
        nal_bytes = '{8'h00, 8'h00, 8'h01, 8'h7C, 8'h11, 8'h22, 8'h33};
        send_nal(1'b0);
        // start code only: no results
        nal_bytes = '{8'h00, 8'h00, 8'h00, 8'h01};
        send_nal(1'b0);
        // lone byte with length zero, read as one
        send_byte(8'h5A, '0, 32'hFFFF_FFFF);
        // maximum length that shrinks on the last beat
        send_byte(8'hFF, '1, 32'h0000_0000);
        send_byte(8'h00, '1, 32'h1234_5678);
        send_byte(8'h80, 24'd1, 32'h1234_5678);
        // NAL ends while the code is still being checked: held zeros go out as data
        nal_bytes = '{8'h00, 8'h00};
        send_nal(1'b0);
        drain();
        // limit below three: one-byte chunks
        write_reg(CFG_MAX_PAYLOAD, 32'd0);
        nal_bytes = '{8'hE1, 8'hFF, 8'h80};
        send_nal(1'b0);
        // fragmented NAL of one byte: header only, no packets
        nal_bytes = '{8'h9F};
        send_nal(1'b0);
        drain();

        // ---- random, one register setting per phase ----
        sent = 0;
        step = 0;
        while (sent < RANDOM_BYTES)
        begin
            case (step % 5)
                0:
                begin
                    write_reg(CFG_MAX_PAYLOAD, $urandom_range(3, 12));
                    write_reg(CFG_INIT_SEQ, $urandom_range(0, 16'hFFFF));
                end
                1:
                begin
                    write_reg(CFG_MAX_PAYLOAD, 32'd3);
                    write_reg(CFG_PAYLOAD_TYPE, 32'd0);
                    write_reg(CFG_SSRC, 32'd0);
                end
                2:
                begin
                    write_reg(CFG_MAX_PAYLOAD, 32'd1460);
                    write_reg(CFG_PAYLOAD_TYPE, $urandom_range(0, 127));
                    write_reg(CFG_SSRC, $urandom());
                end
                3:
                    write_reg(CFG_MAX_PAYLOAD, $urandom_range(0, 2));
                default:
                begin
                    write_reg(CFG_MAX_PAYLOAD, 32'd2047);
                    write_reg(CFG_INIT_SEQ, 32'h0000_FFFF);
                end
            endcase
            gaps_on    = ($urandom_range(0, 3) != 0);
            phase_sent = 0;

            // back pressure: receiver holds off while a long NAL streams in with no
            // gaps; one-byte chunks triple the output so the block must stall input
            if (step == 1)
            begin
                gaps_on   = 1'b0;
                hold_req  = 1'b1;
                nal_bytes = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h5C};
                repeat (40) nal_bytes.insert(nal_bytes.size(), 8'($urandom_range(0, 255)));
                send_nal(1'b0);
                phase_sent += nal_bytes.size();
                gaps_on = 1'b1;
            end

            while (phase_sent < PHASE_BYTES)
            begin
                build_random_nal();
                send_nal($urandom_range(0, 3) == 0);
                phase_sent += nal_bytes.size();
            end
            sent += phase_sent;
            drain();
            step++;
        end

        if (errors == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ h264_rtp_fua_packetizer.f @@
hw/rtl/hrfp_pkg.sv
hw/rtl/hrfp_cmd_fifo.sv
hw/rtl/hrfp_front.sv
hw/rtl/hrfp_back.sv
hw/rtl/h264_rtp_fua_packetizer.sv
dv/fua_packet_checker.sv
dv/tb.sv
